// File: rtl/spl_pkg.sv
// Shared types, codes and defaults for the sorted priority list.
package spl_pkg;

	// Defaults for the top-level parameters.
	localparam int SPL_CAPACITY = 64;
	localparam int SPL_ID_BITS  = 10;

	// Fixed widths of the request and response fields.
	localparam int OP_W       = 3;
	localparam int ENTRY_ID_W = 10;
	localparam int COST_W     = 24;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 7;

	// Operation codes of a request.
	typedef enum logic [OP_W-1:0] {
		OP_INS_COST  = 3'd0,
		OP_INS_FRONT = 3'd1,
		OP_INS_BACK  = 3'd2,
		OP_DEL_FRONT = 3'd3,
		OP_DEL_BACK  = 3'd4,
		OP_DEL_ID    = 3'd5
	} op_t;

	// Status codes of a response.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// Request payload.
	typedef struct packed {
		logic [OP_W-1:0]       operation;
		logic [ENTRY_ID_W-1:0] entry_id;
		logic [COST_W-1:0]     entry_cost;
	} req_t;

	// Response payload.
	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [ENTRY_ID_W-1:0] removed_id;
		logic [COST_W-1:0]     removed_cost;
		logic [COUNT_W-1:0]    entry_count;
		logic                  is_empty;
	} rsp_t;

	// Read address select: logical front, logical back, or next scan slot.
	typedef enum logic [1:0] {
		RD_FIRST = 2'd0,
		RD_LAST  = 2'd1,
		RD_NEXT  = 2'd2
	} rd_sel_t;

	// Write address select: the slot before the scan slot, or one past the back.
	typedef enum logic {
		WA_PREV = 1'b0,
		WA_END  = 1'b1
	} wa_sel_t;

	// Head and count update applied when a request finishes.
	typedef enum logic [2:0] {
		UPD_NONE       = 3'd0,
		UPD_PUSH_FRONT = 3'd1,
		UPD_PUSH_BACK  = 3'd2,
		UPD_POP_FRONT  = 3'd3,
		UPD_POP        = 3'd4
	} upd_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    e_clr;
		logic    e_inc;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wa_sel_t wa_sel;
		logic    wd_new;
		logic    sav_en;
		logic    finish;
		logic    rsp_removed;
		upd_t    upd;
		status_t status;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic empty;
		logic at_end;
		logic cost_gt;
		logic id_eq;
		logic res_free;
	} sts_t;

endpackage

// File: rtl/sorted_priority_list.sv
// Sorted priority list: an ordered list of entries (id, cost) for a best-first search.
//
// Requests come in on req_valid/req_ready with a req_t payload; one response per
// request leaves on rsp_valid/rsp_ready with an rsp_t payload, in request order.
// Operations: insert by cost (after all entries of equal or lower cost), insert at
// front or back, remove front, remove back, remove first matching id.
// Entries sit in a circular slot memory with one write and one registered read
// port; ordered insert and remove by id walk it one slot per cycle.
// Insert front or back goes straight to the finish state, remove front or back reads
// the entry first, insert by cost walks the entries ahead of the new one, and remove
// by id walks all entries whether the id is found or not. Full, empty and unused codes skip the memory.
// One request is in flight at a time; req_ready is high while the sequencer idles,
// and the next request can be taken while the last response is still waiting.
// A stalled receiver holds the response register; a finished request then waits
// before committing, so nothing is lost. Reset empties the list at once; slot
// contents are not cleared, since data read from slots at or past the count is never used.
module sorted_priority_list #(
	parameter int CAPACITY = spl_pkg::SPL_CAPACITY,
	parameter int ID_BITS  = spl_pkg::SPL_ID_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  spl_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output spl_pkg::rsp_t rsp
);
	import spl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	spl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (op_t'(req.operation)),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Storage and arithmetic.
	spl_dpath #(
		.CAPACITY (CAPACITY),
		.ID_BITS  (ID_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

// File: rtl/spl_ctrl.sv
// Controller state machine that sequences each request over the slot memory.
module spl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  spl_pkg::op_t  req_op,
	output logic          req_ready,
	input  spl_pkg::sts_t sts,
	output spl_pkg::cmd_t cmd
);
	import spl_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_PRIME  = 7'b0000010,
		S_SCAN   = 7'b0000100,
		S_SHIFT  = 7'b0001000,
		S_FETCH  = 7'b0010000,
		S_TAKE   = 7'b0100000,
		S_FINISH = 7'b1000000
	} state_t;

	state_t  state_q, state_d;
	op_t     op_q, op_d;
	status_t stat_q, stat_d;

	assign req_ready = (state_q == S_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		stat_d  = stat_q;
		cmd     = '0;
		cmd.status = stat_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load  = 1'b1;
					cmd.e_clr = 1'b1;
					op_d      = req_op;
					stat_d    = ST_OK;
					case (req_op)
						OP_INS_COST: begin
							if (sts.full) begin
								stat_d  = ST_FULL;
								state_d = S_FINISH;
							end else begin
								state_d = S_PRIME;
							end
						end
						OP_INS_FRONT, OP_INS_BACK: begin
							if (sts.full) begin
								stat_d = ST_FULL;
							end
							state_d = S_FINISH;
						end
						OP_DEL_FRONT, OP_DEL_BACK: begin
							if (sts.empty) begin
								stat_d  = ST_EMPTY;
								state_d = S_FINISH;
							end else begin
								state_d = S_FETCH;
							end
						end
						OP_DEL_ID: begin
							if (sts.empty) begin
								stat_d  = ST_EMPTY;
								state_d = S_FINISH;
							end else begin
								state_d = S_PRIME;
							end
						end
						default: begin
							state_d = S_FINISH;
						end
					endcase
				end
			end
			S_PRIME: begin
				// Read the front entry to start the scan.
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_FIRST;
				state_d    = S_SCAN;
			end
			S_SCAN: begin
				if (op_q == OP_INS_COST) begin
					// Entries of lower or equal cost move one slot toward the front.
					cmd.wr_en  = 1'b1;
					cmd.wa_sel = WA_PREV;
					if (sts.at_end || sts.cost_gt) begin
						cmd.wd_new = 1'b1;
						state_d    = S_FINISH;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_NEXT;
						cmd.e_inc  = 1'b1;
					end
				end else begin
					if (sts.at_end) begin
						stat_d  = ST_NOT_FOUND;
						state_d = S_FINISH;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_NEXT;
						cmd.e_inc  = 1'b1;
						if (sts.id_eq) begin
							cmd.sav_en = 1'b1;
							state_d    = S_SHIFT;
						end
					end
				end
			end
			S_SHIFT: begin
				// Entries behind the removed one move one slot toward the front.
				if (sts.at_end) begin
					state_d = S_FINISH;
				end else begin
					cmd.wr_en  = 1'b1;
					cmd.wa_sel = WA_PREV;
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_NEXT;
					cmd.e_inc  = 1'b1;
				end
			end
			S_FETCH: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = (op_q == OP_DEL_FRONT) ? RD_FIRST : RD_LAST;
				state_d    = S_TAKE;
			end
			S_TAKE: begin
				cmd.sav_en = 1'b1;
				state_d    = S_FINISH;
			end
			S_FINISH: begin
				// Commit and post the response once the output register is free.
				if (sts.res_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
					if (stat_q == ST_OK) begin
						cmd.rsp_removed = op_q inside {OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_ID};
						case (op_q)
							OP_INS_COST: begin
								cmd.upd = UPD_PUSH_FRONT;
							end
							OP_INS_FRONT: begin
								cmd.upd    = UPD_PUSH_FRONT;
								cmd.wr_en  = 1'b1;
								cmd.wa_sel = WA_PREV;
								cmd.wd_new = 1'b1;
							end
							OP_INS_BACK: begin
								cmd.upd    = UPD_PUSH_BACK;
								cmd.wr_en  = 1'b1;
								cmd.wa_sel = WA_END;
								cmd.wd_new = 1'b1;
							end
							OP_DEL_FRONT: begin
								cmd.upd = UPD_POP_FRONT;
							end
							OP_DEL_BACK, OP_DEL_ID: begin
								cmd.upd = UPD_POP;
							end
							default: begin
								cmd.upd = UPD_NONE;
							end
						endcase
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_INS_COST;
			stat_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			stat_q  <= stat_d;
		end
	end

endmodule

// File: rtl/spl_dpath.sv
// Datapath: circular slot memory, head and count, scan index and response register.
module spl_dpath #(
	parameter int CAPACITY = spl_pkg::SPL_CAPACITY,
	parameter int ID_BITS  = spl_pkg::SPL_ID_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  spl_pkg::req_t req,
	input  spl_pkg::cmd_t cmd,
	output spl_pkg::sts_t sts,
	input  logic          rsp_ready,
	output logic          rsp_valid,
	output spl_pkg::rsp_t rsp
);
	import spl_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = IDX_W + 1;
	localparam logic [SUM_W-1:0] CAP_S    = SUM_W'(CAPACITY);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] CAP_C    = CNT_W'(CAPACITY);

	// Folds a head-relative sum below twice the capacity back into the slot range.
	function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] r;
		r = (s >= CAP_S) ? (s - CAP_S) : s;
		return r[IDX_W-1:0];
	endfunction

	logic [ID_BITS-1:0] id_mem_q   [CAPACITY];
	logic [COST_W-1:0]  cost_mem_q [CAPACITY];

	logic [ID_BITS-1:0] id_q, rd_id_q, sav_id_q, wr_id;
	logic [COST_W-1:0]  cost_q, rd_cost_q, sav_cost_q, wr_cost;
	logic [IDX_W-1:0]   head_q, head_upd, head_inc, head_dec;
	logic [CNT_W-1:0]   cnt_q, cnt_upd, e_q;
	logic [IDX_W-1:0]   e_addr, prev_addr, end_addr, rd_addr, wr_addr;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	// Physical slot addresses, relative to the head of the list.
	always_comb begin
		e_addr    = wrap_idx(SUM_W'(head_q) + SUM_W'(e_q));
		prev_addr = (e_addr == '0) ? LAST_IDX : (e_addr - IDX_W'(1));
		end_addr  = wrap_idx(SUM_W'(head_q) + SUM_W'(cnt_q));
		case (cmd.rd_sel)
			RD_FIRST: rd_addr = head_q;
			RD_LAST:  rd_addr = wrap_idx(SUM_W'(head_q) + SUM_W'(cnt_q) - SUM_W'(1));
			RD_NEXT:  rd_addr = wrap_idx(SUM_W'(head_q) + SUM_W'(e_q) + SUM_W'(1));
			default:  rd_addr = head_q;
		endcase
		wr_addr = (cmd.wa_sel == WA_END) ? end_addr : prev_addr;
		wr_id   = cmd.wd_new ? id_q : rd_id_q;
		wr_cost = cmd.wd_new ? cost_q : rd_cost_q;
	end

	// Head and count after the finishing request.
	always_comb begin
		head_inc = (head_q == LAST_IDX) ? '0 : (head_q + IDX_W'(1));
		head_dec = (head_q == '0) ? LAST_IDX : (head_q - IDX_W'(1));
		head_upd = head_q;
		cnt_upd  = cnt_q;
		case (cmd.upd)
			UPD_NONE: begin
			end
			UPD_PUSH_FRONT: begin
				head_upd = head_dec;
				cnt_upd  = cnt_q + CNT_W'(1);
			end
			UPD_PUSH_BACK: begin
				cnt_upd = cnt_q + CNT_W'(1);
			end
			UPD_POP_FRONT: begin
				head_upd = head_inc;
				cnt_upd  = cnt_q - CNT_W'(1);
			end
			UPD_POP: begin
				cnt_upd = cnt_q - CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	// Status toward the controller.
	always_comb begin
		sts.full     = (cnt_q == CAP_C);
		sts.empty    = (cnt_q == '0);
		sts.at_end   = (e_q == cnt_q);
		sts.cost_gt  = (rd_cost_q > cost_q);
		sts.id_eq    = (rd_id_q == id_q);
		sts.res_free = !rsp_valid_q || rsp_ready;
	end

	// Slot memory with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			id_mem_q[wr_addr]   <= wr_id;
			cost_mem_q[wr_addr] <= wr_cost;
		end
		if (cmd.rd_en) begin
			rd_id_q   <= id_mem_q[rd_addr];
			rd_cost_q <= cost_mem_q[rd_addr];
		end
	end

	// Request operands, removed entry and response payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q   <= ID_BITS'(req.entry_id);
			cost_q <= req.entry_cost;
		end
		if (cmd.sav_en) begin
			sav_id_q   <= rd_id_q;
			sav_cost_q <= rd_cost_q;
		end
		if (cmd.finish) begin
			rsp_q.status       <= cmd.status;
			rsp_q.removed_id   <= cmd.rsp_removed ? ENTRY_ID_W'(sav_id_q) : '0;
			rsp_q.removed_cost <= cmd.rsp_removed ? sav_cost_q : '0;
			rsp_q.entry_count  <= COUNT_W'(cnt_upd);
			rsp_q.is_empty     <= (cnt_upd == '0);
		end
	end

	// List bookkeeping and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			cnt_q       <= '0;
			e_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.e_clr) begin
				e_q <= '0;
			end else if (cmd.e_inc) begin
				e_q <= e_q + CNT_W'(1);
			end
			if (cmd.finish) begin
				head_q <= head_upd;
				cnt_q  <= cnt_upd;
			end
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/sorted_priority_list_chk.sv
// Port-level checker for the sorted priority list, bound to the top level.
module sorted_priority_list_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input spl_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input spl_pkg::rsp_t rsp
);
	import spl_pkg::*;

	// A stalled response holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// Only one request is in flight: taking one closes the request side.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request side stayed open after a request");

	// A failed request removes nothing.
	a_fail_no_removal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |-> (rsp.removed_id == '0) && (rsp.removed_cost == '0))
		else $error("failed request reports a removed entry");

	// An empty list reports a zero count.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_empty |-> (rsp.entry_count == '0))
		else $error("empty flag with nonzero count");

endmodule

bind sorted_priority_list sorted_priority_list_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

// File: tb/sv/spl_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the sorted priority list: a model of the list and the expected responses.
package spl_scoreboard_pkg;
	import spl_pkg::*;

	class spl_scoreboard;
		int capacity;
		logic [ENTRY_ID_W-1:0] entry_ids[$];
		logic [COST_W-1:0]     entry_costs[$];
		rsp_t                  expected_rsps[$];
		int unsigned           errors;

		function new(int cap);
			capacity = cap;
			errors = 0;
		endfunction

		// Applies one request to the list model and returns the response it must produce.
		function rsp_t apply_request(req_t r);
			rsp_t result;
			int pos;
			result = '0;
			pos = 0;
			case (r.operation)
				OP_INS_COST, OP_INS_FRONT, OP_INS_BACK: begin
					if (entry_ids.size() >= capacity) begin
						result.status = ST_FULL;
					end else begin
						// Ordered insert goes after every entry of equal or lower cost.
						if (r.operation == OP_INS_COST) begin
							while (pos < entry_ids.size() && entry_costs[pos] <= r.entry_cost)
								pos++;
						end else if (r.operation == OP_INS_BACK) begin
							pos = entry_ids.size();
						end
						entry_ids.insert(pos, r.entry_id);
						entry_costs.insert(pos, r.entry_cost);
					end
				end
				OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_ID: begin
					if (entry_ids.size() == 0) begin
						result.status = ST_EMPTY;
					end else begin
						// Remove by id takes the match nearest the front.
						if (r.operation == OP_DEL_BACK) begin
							pos = entry_ids.size() - 1;
						end else if (r.operation == OP_DEL_ID) begin
							while (pos < entry_ids.size() && entry_ids[pos] != r.entry_id)
								pos++;
						end
						if (pos < entry_ids.size()) begin
							result.removed_id = entry_ids[pos];
							result.removed_cost = entry_costs[pos];
							entry_ids.delete(pos);
							entry_costs.delete(pos);
						end else begin
							result.status = ST_NOT_FOUND;
						end
					end
				end
				default: ;
			endcase
			result.entry_count = COUNT_W'(entry_ids.size());
			result.is_empty = (entry_ids.size() == 0);
			return result;
		endfunction

		// Called for every accepted request.
		function void note_request(req_t r);
			expected_rsps.push_back(apply_request(r));
		endfunction

		// Called for every accepted response; compares it with the oldest expectation.
		function void check_response(rsp_t got);
			rsp_t want;
			if (expected_rsps.size() == 0) begin
				errors++;
				$display("%0t: response %h with no request outstanding", $time, got);
				return;
			end
			want = expected_rsps.pop_front();
			if (got.status !== want.status) begin
				errors++;
				$display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
			end
			if (got.removed_id !== want.removed_id) begin
				errors++;
				$display("%0t: removed_id expected %0d, actual %0d", $time,
					want.removed_id, got.removed_id);
			end
			if (got.removed_cost !== want.removed_cost) begin
				errors++;
				$display("%0t: removed_cost expected %0d, actual %0d", $time,
					want.removed_cost, got.removed_cost);
			end
			if (got.entry_count !== want.entry_count) begin
				errors++;
				$display("%0t: entry_count expected %0d, actual %0d", $time,
					want.entry_count, got.entry_count);
			end
			if (got.is_empty !== want.is_empty) begin
				errors++;
				$display("%0t: is_empty expected %0d, actual %0d", $time,
					want.is_empty, got.is_empty);
			end
		endfunction

		function int unsigned pending();
			return expected_rsps.size();
		endfunction
	endclass

endpackage

// File: tb/sv/tb_sorted_priority_list.sv
`timescale 1ns / 100ps
// Testbench top for the sorted priority list: directed and random requests against a list model.
module tb_sorted_priority_list;
	import spl_pkg::*;
	import spl_scoreboard_pkg::*;

	localparam int CAPACITY      = SPL_CAPACITY;
	localparam int ID_BITS       = SPL_ID_BITS;
	localparam int ITEM_TOTAL    = 1350;
	localparam int QUIET_FROM    = 1150;
	localparam int CYCLE_LIMIT   = 800000;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 2 * CAPACITY + 20;

	// Operation codes the block does not use; they must leave the list alone.
	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

	localparam logic [COST_W-1:0]     COST_MAX = '1;
	localparam logic [ENTRY_ID_W-1:0] ID_MAX   = '1;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	int unsigned cycle_count = 0;
	int unsigned sent = 0;
	// Chance in percent of a stall burst: per request on the sender, per cycle on the receiver.
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;

	spl_scoreboard open_list = new(CAPACITY);

	sorted_priority_list #(
		.CAPACITY(CAPACITY),
		.ID_BITS (ID_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Response side: random stall bursts, checking every accepted response.
	initial begin
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) < recv_idle_pct) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(0, 18)) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && rsp_valid && rsp_ready)
			open_list.check_response(rsp);
	end

	// Hard stop if the block hangs.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: timeout with %0d responses outstanding", $time, open_list.pending());
		$display("tb_sorted_priority_list: errors");
		$finish;
	end

	// Presents one request, holds it until accepted, then maybe leaves a gap.
	task automatic send_request(input logic [OP_W-1:0] op, input logic [ENTRY_ID_W-1:0] id,
			input logic [COST_W-1:0] cost);
		req_t r;
		r.operation = op;
		r.entry_id = id;
		r.entry_cost = cost;
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		open_list.note_request(r);
		sent++;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// Costs lean toward a narrow band so that ties are common.
	function automatic logic [COST_W-1:0] pick_cost();
		case ($urandom_range(0, 4))
			0, 1: return COST_W'($urandom_range(0, 15));
			2: return $urandom_range(0, 1) ? COST_MAX : '0;
			default: return COST_W'($urandom());
		endcase
	endfunction

	// Ids lean toward a narrow band so that duplicates are common.
	function automatic logic [ENTRY_ID_W-1:0] pick_id();
		if ($urandom_range(0, 1))
			return ENTRY_ID_W'($urandom_range(0, 31));
		return ENTRY_ID_W'($urandom_range(0, 1023));
	endfunction

	// One random request; ins_pct steers the list toward full or empty.
	task automatic random_request(input int unsigned ins_pct);
		int unsigned roll;
		int unsigned held;
		logic [ENTRY_ID_W-1:0] id;
		roll = $urandom_range(0, 99);
		held = open_list.entry_ids.size();
		if (roll < 2) begin
			send_request($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7, pick_id(), pick_cost());
		end else if (roll < 2 + ins_pct) begin
			case ($urandom_range(0, 4))
				0: send_request(OP_INS_FRONT, pick_id(), pick_cost());
				1: send_request(OP_INS_BACK, pick_id(), pick_cost());
				default: send_request(OP_INS_COST, pick_id(), pick_cost());
			endcase
		end else begin
			case ($urandom_range(0, 4))
				0, 1: send_request(OP_DEL_FRONT, pick_id(), pick_cost());
				2: send_request(OP_DEL_BACK, pick_id(), pick_cost());
				default: begin
					// Mostly remove an id that is really held, sometimes a stray one.
					if (held > 0 && $urandom_range(0, 4) != 0)
						id = open_list.entry_ids[$urandom_range(0, held - 1)];
					else
						id = pick_id();
					send_request(OP_DEL_ID, id, pick_cost());
				end
			endcase
		end
	endtask

	// Main sequence: reset, directed requests, random phases, drain and verdict.
	initial begin
		int unsigned seg_left;
		int unsigned ins_pct;
		int unsigned waited;
		bit first_seg;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Removing from an empty list, then an unused code.
		send_request(OP_DEL_FRONT, ID_MAX, COST_MAX);
		send_request(OP_DEL_BACK, '0, '0);
		send_request(OP_DEL_ID, 10'h155, '0);
		send_request(OP_SPARE_6, 10'h2AA, 24'hAAAAAA);
		// A one-entry list is only emptied when the id matches.
		send_request(OP_INS_COST, ID_MAX, COST_MAX);
		send_request(OP_DEL_ID, 10'h155, 24'h555555);
		send_request(OP_SPARE_7, '0, 24'h555555);
		send_request(OP_DEL_ID, ID_MAX, '0);
		// Ordered inserts with a tie, then front and back inserts and a duplicate id.
		send_request(OP_INS_COST, '0, '0);
		send_request(OP_INS_COST, 10'd1, 24'd100);
		send_request(OP_INS_COST, 10'd2, 24'd100);
		send_request(OP_INS_COST, 10'd3, 24'd50);
		send_request(OP_INS_FRONT, 10'd1, COST_MAX);
		send_request(OP_INS_BACK, 10'h2AA, 24'h555555);
		send_request(OP_INS_COST, 10'h155, COST_MAX);
		// Removals of each kind, a missing id, then empty the list and go past empty.
		send_request(OP_DEL_ID, 10'd1, '0);
		send_request(OP_DEL_BACK, '0, '0);
		send_request(OP_DEL_FRONT, '0, '0);
		send_request(OP_DEL_ID, 10'h3FF, '0);
		repeat (4) send_request(OP_DEL_FRONT, '0, '0);
		send_request(OP_DEL_BACK, ID_MAX, COST_MAX);

		// Random phases that fill, drain or churn the list under varying stalls.
		first_seg = 1'b1;
		while (sent < ITEM_TOTAL) begin
			seg_left = $urandom_range(40, 120);
			case ($urandom_range(0, 3))
				0: ins_pct = 90;
				1: ins_pct = 12;
				default: ins_pct = 48;
			endcase
			if (first_seg) begin
				seg_left = 120;
				ins_pct = 90;
				first_seg = 1'b0;
			end
			if (sent >= QUIET_FROM) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else begin
				case ($urandom_range(0, 2))
					0: begin
						send_idle_pct = 0;
						recv_idle_pct = 0;
					end
					1: begin
						send_idle_pct = 8;
						recv_idle_pct = 4;
					end
					default: begin
						send_idle_pct = 40;
						recv_idle_pct = 20;
					end
				endcase
			end
			while (seg_left > 0 && sent < ITEM_TOTAL) begin
				random_request(ins_pct);
				seg_left--;
			end
		end
		req_valid <= 1'b0;

		// Wait for the outstanding responses, then let the block settle.
		waited = 0;
		while (open_list.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (open_list.errors == 0 && open_list.pending() == 0) begin
			$display("tb_sorted_priority_list: clean");
		end else begin
			if (open_list.pending() != 0)
				$display("%0t: %0d responses never arrived", $time, open_list.pending());
			$display("tb_sorted_priority_list: errors");
		end
		$finish;
	end

endmodule

// File: sorted_priority_list.f
rtl/spl_pkg.sv
rtl/spl_ctrl.sv
rtl/spl_dpath.sv
rtl/sorted_priority_list.sv
rtl/sorted_priority_list_chk.sv
tb/sv/spl_scoreboard_pkg.sv
tb/sv/tb_sorted_priority_list.sv
